// ----- hw/rtl/cbp_pkg.sv -----
package cbp_pkg;

    localparam int COEF_W   = 16;
    localparam int CFG_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int TOTAL_W  = 13;
    localparam int PCOUNT_W = 3;
    localparam int GROUP_N  = 3;
    localparam int GCOUNT_W = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 5'd14;
    localparam logic [CFG_W-1:0] WIDTH_LIMIT = 5'd16;

    // up to three bytes produced by one coefficient, first byte in the top bits
    typedef struct packed {
        logic [GROUP_N*BYTE_W-1:0] bytes;
        logic [GCOUNT_W-1:0]       count;
        logic                      fin;
        logic [TOTAL_W-1:0]        base;
    } cbp_group_t;

endpackage

// ----- hw/rtl/cbp_pack.sv -----
module cbp_pack
    import cbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [COEF_W-1:0]   coefficient_value,
    input  logic                final_coefficient,
    input  logic                group_ready,
    output logic                group_load,
    output cbp_group_t          group
);

    logic [CFG_W-1:0]    width_reg;
    logic                in_valid_reg, in_valid_next;
    logic [COEF_W-1:0]   coef_reg;
    logic                fin_reg;
    logic [BYTE_W-1:0]   pend_reg, pend_next;
    logic [PCOUNT_W-1:0] pcount_reg, pcount_next;
    logic [TOTAL_W-1:0]  counter_reg, counter_next;

    logic                accept;
    logic [CFG_W-1:0]    eff_width;
    logic [COEF_W-1:0]   rev;
    logic [GROUP_N*BYTE_W-1:0] stream;
    logic [CFG_W-1:0]    total_bits;
    logic [GCOUNT_W-1:0] full_bytes;
    logic                flush;

    assign group_load = in_valid_reg && group_ready;
    assign in_stall   = in_valid_reg && !group_load;
    assign accept     = in_valid && !in_stall;

    assign eff_width = (width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : width_reg;

    // masked coefficient, bit 0 moved to the top so it leaves first
    always_comb
    begin
        for (int k = 0; k < COEF_W; k++)
        begin
            rev[COEF_W-1-k] = coef_reg[k] && (CFG_W'(k) < eff_width);
        end
    end

    assign stream = {pend_reg, {COEF_W{1'b0}}}
                  | ({rev, {BYTE_W{1'b0}}} >> pcount_reg);

    assign total_bits = CFG_W'(pcount_reg) + eff_width;
    assign full_bytes = total_bits[CFG_W-1:PCOUNT_W];
    assign flush      = fin_reg && (total_bits[PCOUNT_W-1:0] != '0);

    always_comb
    begin
        group.bytes = stream;
        group.count = full_bytes + GCOUNT_W'(flush);
        group.fin   = fin_reg;
        group.base  = counter_reg;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (group_load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pend_next    = pend_reg;
        pcount_next  = pcount_reg;
        counter_next = counter_reg;
        if (group_load)
        begin
            if (fin_reg)
            begin
                pend_next    = '0;
                pcount_next  = '0;
                counter_next = '0;
            end
            else
            begin
                case (full_bytes)
                    2'd0:    pend_next = stream[3*BYTE_W-1:2*BYTE_W];
                    2'd1:    pend_next = stream[2*BYTE_W-1:BYTE_W];
                    default: pend_next = stream[BYTE_W-1:0];
                endcase
                pcount_next  = total_bits[PCOUNT_W-1:0];
                counter_next = counter_reg + TOTAL_W'(full_bytes);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            in_valid_reg <= 1'b0;
            pend_reg     <= '0;
            pcount_reg   <= '0;
            counter_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
            pend_reg     <= pend_next;
            pcount_reg   <= pcount_next;
            counter_reg  <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coef_reg <= coefficient_value;
            fin_reg  <= final_coefficient;
        end
    end

endmodule

// ----- hw/rtl/cbp_out.sv -----
module cbp_out
    import cbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                group_load,
    input  cbp_group_t          group,
    output logic                group_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BYTE_W-1:0]   packed_byte,
    output logic                final_byte,
    output logic [TOTAL_W-1:0]  total_bytes
);

    logic [GROUP_N*BYTE_W-1:0] bytes_reg;
    logic                      fin_reg;
    logic [TOTAL_W-1:0]        base_reg;
    logic [GCOUNT_W-1:0]       left_reg, left_next;
    logic [GCOUNT_W-1:0]       idx_reg, idx_next;
    logic                      transfer;

    assign out_valid   = (left_reg != '0);
    assign transfer    = out_valid && !out_stall;
    assign group_ready = (left_reg == '0) || ((left_reg == GCOUNT_W'(1)) && !out_stall);

    always_comb
    begin
        case (idx_reg)
            2'd0:    packed_byte = bytes_reg[3*BYTE_W-1:2*BYTE_W];
            2'd1:    packed_byte = bytes_reg[2*BYTE_W-1:BYTE_W];
            default: packed_byte = bytes_reg[BYTE_W-1:0];
        endcase
    end

    assign final_byte  = fin_reg && (left_reg == GCOUNT_W'(1));
    assign total_bytes = base_reg + TOTAL_W'(idx_reg) + TOTAL_W'(1);

    always_comb
    begin
        left_next = left_reg;
        idx_next  = idx_reg;
        if (group_load)
        begin
            left_next = group.count;
            idx_next  = '0;
        end
        else if (transfer)
        begin
            left_next = left_reg - GCOUNT_W'(1);
            idx_next  = idx_reg + GCOUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (group_load)
        begin
            bytes_reg <= group.bytes;
            fin_reg   <= group.fin;
            base_reg  <= group.base;
        end
    end

endmodule

// ----- hw/rtl/coefficient_bit_packer.sv -----
// Packs the low cfg_wdata bits (clamped to 16) of each coefficient into bytes,
// coefficient bit 0 first, each byte filled from its msb down; the final
// coefficient flushes a zero-padded partial byte, and the last byte carries
// final_byte and the polynomial's byte count. Input passes through one holding
// register into the packing logic, which hands up to three bytes to an output
// buffer that drains one byte per transfer. A coefficient waits in the holding
// register until the output buffer can take its bytes: with a steady output,
// width 8 or less runs one coefficient per cycle and widths 9 to 16 are limited
// by the single byte-wide output port. Write the width only while the block is
// idle.
module coefficient_bit_packer
    import cbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [COEF_W-1:0]   coefficient_value,
    input  logic                final_coefficient,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BYTE_W-1:0]   packed_byte,
    output logic                final_byte,
    output logic [TOTAL_W-1:0]  total_bytes
);

    logic       group_ready;
    logic       group_load;
    cbp_group_t group;

    cbp_pack u_pack (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .coefficient_value (coefficient_value),
        .final_coefficient (final_coefficient),
        .group_ready       (group_ready),
        .group_load        (group_load),
        .group             (group)
    );

    cbp_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .group_load  (group_load),
        .group       (group),
        .group_ready (group_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_byte (packed_byte),
        .final_byte  (final_byte),
        .total_bytes (total_bytes)
    );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    import cbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PERCENT   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               fin;
        logic [TOTAL_W-1:0] total;
    } packed_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic [COEF_W-1:0]   coefficient_value;
    logic                final_coefficient;
    logic                out_valid;
    logic                out_stall;
    logic [BYTE_W-1:0]   packed_byte;
    logic                final_byte;
    logic [TOTAL_W-1:0]  total_bytes;

    // predictor state
    logic [CFG_W-1:0]    width_setting;
    logic [BYTE_W-1:0]   build_bits;
    int                  build_count;
    logic [TOTAL_W-1:0]  poly_bytes;
    packed_result_t      packed_bytes_due[$];

    bit steady_flow;
    int error_count;
    int coefficients_sent;
    int polynomials_sent;
    int bytes_checked;
    int widths_written;

    coefficient_bit_packer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .coefficient_value (coefficient_value),
        .final_coefficient (final_coefficient),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .packed_byte       (packed_byte),
        .final_byte        (final_byte),
        .total_bytes       (total_bytes)
    );

    always #5ns clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // computes the bytes one coefficient produces and queues them
    function automatic void pack_coefficient(input logic [COEF_W-1:0] value, input logic fin);
        int eff_width;
        int made;
        packed_result_t r;
        eff_width = (width_setting > WIDTH_LIMIT) ? int'(WIDTH_LIMIT) : int'(width_setting);
        made = 0;
        for (int k = 0; k < eff_width; k++)
        begin
            build_bits[7 - build_count] = value[k];
            build_count++;
            if (build_count == 8)
            begin
                poly_bytes = poly_bytes + TOTAL_W'(1);
                r.data  = build_bits;
                r.fin   = 1'b0;
                r.total = poly_bytes;
                packed_bytes_due.push_back(r);
                made++;
                build_bits  = '0;
                build_count = 0;
            end
        end
        if (fin)
        begin
            if (build_count > 0)
            begin
                poly_bytes = poly_bytes + TOTAL_W'(1);
                r.data  = build_bits;
                r.fin   = 1'b1;
                r.total = poly_bytes;
                packed_bytes_due.push_back(r);
            end
            else if (made > 0)
            begin
                // final on a byte boundary marks the last full byte
                packed_bytes_due[packed_bytes_due.size() - 1].fin = 1'b1;
            end
            build_bits  = '0;
            build_count = 0;
            poly_bytes  = '0;
        end
    endfunction

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        packed_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_checked++;
            if (packed_bytes_due.size() == 0)
            begin
                log_failure($sformatf("unexpected byte %02h final %0b total %0d",
                                      packed_byte, final_byte, total_bytes));
            end
            else
            begin
                want = packed_bytes_due.pop_front();
                if (packed_byte !== want.data || final_byte !== want.fin
                    || total_bytes !== want.total)
                    log_failure($sformatf(
                        "byte exp %02h/%0b/%0d got %02h/%0b/%0d",
                        want.data, want.fin, want.total,
                        packed_byte, final_byte, total_bytes));
            end
        end
    end

    task automatic send_coefficient(input logic [COEF_W-1:0] value, input logic fin);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        coefficient_value <= value;
        final_coefficient <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pack_coefficient(value, fin);
        coefficients_sent++;
        if (fin)
            polynomials_sent++;
    endtask

    // empty the pipeline, then allow for width-zero items that leave no bytes
    task automatic drain;
        in_valid <= 1'b0;
        while (packed_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(input logic [CFG_W-1:0] w);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_setting = w;
        widths_written++;
    endtask

    task automatic send_polynomial(input int length);
        logic [COEF_W-1:0] value;
        int pick;
        for (int i = 0; i < length; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                value = '0;
            else if (pick == 1)
                value = '1;
            else
                value = COEF_W'($urandom);
            send_coefficient(value, i == length - 1);
        end
    endtask

    task automatic test_reset_width;
        // 42 bits at the reset width: five bytes and a padded partial
        send_coefficient(16'hFFFF, 1'b0);
        send_coefficient(16'h0000, 1'b0);
        send_coefficient(16'hA5C3, 1'b1);
    endtask

    task automatic test_width_edges;
        set_width(5'd16);
        send_coefficient(16'hFFFF, 1'b0);
        send_coefficient(16'h0001, 1'b1);
        set_width(5'd1);
        for (int i = 0; i < 9; i++)
            send_coefficient(COEF_W'(i % 3 == 0 ? 16'hFFFE : 16'h0001) ^ 16'h0001 ^ COEF_W'(i & 1),
                             i == 8);
        set_width(5'd31);
        send_coefficient(16'h8001, 1'b1);
        set_width(5'd8);
        send_coefficient(16'hFF5A, 1'b1);
        set_width(5'd3);
        send_coefficient(16'h0007, 1'b1);
    endtask

    task automatic test_zero_width;
        set_width(5'd0);
        send_coefficient(16'h1234, 1'b1);
        send_coefficient(16'hFFFF, 1'b0);
        send_coefficient(16'h0000, 1'b1);
    endtask

    task automatic test_random_polynomials;
        int phase_widths[10] = '{1, 16, 31, 7, 9, 0, 17, 5, -1, -1};
        int budget;
        int sent;
        int length;
        for (int p = 0; p < 10; p++)
        begin
            if (phase_widths[p] < 0)
                set_width(CFG_W'($urandom_range(0, 31)));
            else
                set_width(CFG_W'(phase_widths[p]));
            budget = (width_setting == 0) ? 8 : 22;
            sent = 0;
            while (sent < budget)
            begin
                length = $urandom_range(1, 12);
                send_polynomial(length);
                sent += length;
            end
        end
    endtask

    task automatic test_back_to_back;
        set_width(5'd16);
        steady_flow = 1'b1;
        send_polynomial(25);
        send_polynomial(15);
        drain();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        in_valid          <= 1'b0;
        coefficient_value <= '0;
        final_coefficient <= 1'b0;
        width_setting      = WIDTH_RESET;
        build_bits         = '0;
        build_count        = 0;
        poly_bytes         = '0;
        steady_flow        = 1'b0;
        error_count        = 0;
        coefficients_sent  = 0;
        polynomials_sent   = 0;
        bytes_checked      = 0;
        widths_written     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_width();
        test_width_edges();
        test_zero_width();
        test_random_polynomials();
        test_back_to_back();

        drain();
        if (packed_bytes_due.size() != 0)
            log_failure($sformatf("%0d bytes never arrived", packed_bytes_due.size()));
        $display("sent %0d coefficients in %0d polynomials under %0d width settings,",
                 coefficients_sent, polynomials_sent, widths_written);
        $display("checked %0d packed bytes, %0d failures", bytes_checked, error_count);
        if (error_count == 0)
            $display("coefficient_bit_packer verification clean");
        else
            $display("coefficient_bit_packer verification failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout waiting for the packer");
        $display("coefficient_bit_packer verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/cbp_pkg.sv
hw/rtl/cbp_pack.sv
hw/rtl/cbp_out.sv
hw/rtl/coefficient_bit_packer.sv
tb/sv/testbench.sv
